### rtl/rk4_pkg.sv
`timescale 1ns / 1ps

package rk4_pkg;

    // Fixed-point format of all x, y, h and slope values
    localparam int FRAC_BITS = 16;

    // Defaults for the top-level parameters
    localparam int MAX_STEPS_DEF   = 63;
    localparam int CORDIC_ITER_DEF = 20;

    // Field widths
    localparam int WORD_W  = 32;
    localparam int STEP_W  = 21;
    localparam int COUNT_W = 6;
    localparam int ACC_W   = 40;
    localparam int CORD_W  = 34;

    // Config register indexes
    localparam logic [0:0] REG_STEP_SIZE  = 1'b0;
    localparam logic [0:0] REG_STEP_COUNT = 1'b1;

    localparam logic [STEP_W-1:0]  STEP_SIZE_RST  = STEP_W'(49152);
    localparam logic [COUNT_W-1:0] STEP_COUNT_RST = COUNT_W'(10);

    // Angle constants, Q3.30 rounded to nearest at FRAC_BITS
    localparam longint Q30_TWO_PI  = 64'd6746518852;
    localparam longint Q30_PI      = 64'd3373259426;
    localparam longint Q30_HALF_PI = 64'd1686629713;
    localparam longint ROUND_ADD   = 64'd1 << (29 - FRAC_BITS);
    localparam longint TWO_PI_FX   = (Q30_TWO_PI + ROUND_ADD) >>> (30 - FRAC_BITS);
    localparam longint PI_FX       = (Q30_PI + ROUND_ADD) >>> (30 - FRAC_BITS);
    localparam longint HALF_PI_FX  = (Q30_HALF_PI + ROUND_ADD) >>> (30 - FRAC_BITS);
    localparam int     REM_W       = $clog2(TWO_PI_FX);

    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = CORD_W'(652032874);

    // |sum| / 6 as (|sum| * RECIP6) >> RECIP_SHIFT, exact for |sum| < 2^25
    localparam int                RECIP_SHIFT = 26;
    localparam logic signed [31:0] RECIP6     = 32'sd11184811;

    typedef struct packed {
        logic                     done;
        logic signed [WORD_W-1:0] sin_val;
        logic signed [WORD_W-1:0] cos_val;
    } cs_result_t;

    function automatic logic signed [CORD_W-1:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            5'd24:   v = 32'h0000003F;
            5'd25:   v = 32'h0000001F;
            5'd26:   v = 32'h0000000F;
            5'd27:   v = 32'h00000008;
            5'd28:   v = 32'h00000004;
            5'd29:   v = 32'h00000002;
            default: v = 32'h00000000;
        endcase
        return $signed({2'b00, v});
    endfunction

    // Saturate a widened sum to the signed 32-bit range
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [CORD_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > CORD_W'(64'sh7FFFFFFF)) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -CORD_W'(64'sh80000000)) begin
            r = 32'sh80000000;
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/rk4_cordic.sv
`timescale 1ns / 1ps

// Sin/cos unit: modulo-2pi reduction by reciprocal multiply plus one
// correction subtract, quadrant fold, then one rotation-mode CORDIC
// iteration per cycle.
module rk4_cordic #(
    parameter int ITERATIONS = rk4_pkg::CORDIC_ITER_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [rk4_pkg::WORD_W-1:0] angle,
    output rk4_pkg::cs_result_t               res
);
    localparam int CW = rk4_pkg::CORD_W;
    localparam int RW = rk4_pkg::REM_W;
    localparam int IW = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;
    localparam int QW = 14;

    localparam logic [2:0] CS_IDLE = 3'd0;
    localparam logic [2:0] CS_QUOT = 3'd1;
    localparam logic [2:0] CS_REM  = 3'd2;
    localparam logic [2:0] CS_CORR = 3'd3;
    localparam logic [2:0] CS_FOLD = 3'd4;
    localparam logic [2:0] CS_ITER = 3'd5;
    localparam logic [2:0] CS_DONE = 3'd6;

    localparam logic [RW:0]          TP_U = (RW+1)'(rk4_pkg::TWO_PI_FX);
    localparam logic signed [RW+1:0] TP_S = (RW+2)'(rk4_pkg::TWO_PI_FX);
    localparam logic signed [RW+1:0] PI_S = (RW+2)'(rk4_pkg::PI_FX);
    localparam logic signed [RW+1:0] HP_S = (RW+2)'(rk4_pkg::HALF_PI_FX);

    // floor(2^32 / 2pi); quotient estimate is exact or one low
    localparam longint        RECIP_TP = (64'd1 << 32) / rk4_pkg::TWO_PI_FX;
    localparam logic [QW-1:0] RECIP_U  = QW'(RECIP_TP);

    logic [2:0]           state_reg, state_next;
    logic [31:0]          mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic [QW-1:0]        q_reg, q_next;
    logic [RW:0]          diff_reg, diff_next;
    logic [RW-1:0]        rem_reg, rem_next;
    logic signed [CW-1:0] vx_reg, vx_next, vy_reg, vy_next, z_reg, z_next;
    logic                 flip_reg, flip_next;
    logic [IW-1:0]        it_reg, it_next;

    logic [45:0]          q_prod;
    logic [33:0]          q_back;
    logic signed [RW+1:0] r0, r1, r2;
    logic                 fold_flip;
    logic signed [CW-1:0] dx, dy, at;

    always_comb begin
        q_prod = 46'(mag_reg) * 46'(RECIP_U);
        q_back = 34'(q_reg) * 34'(TP_U);
        r0 = (neg_reg && rem_reg != '0) ? TP_S - $signed({2'b00, rem_reg})
                                         : $signed({2'b00, rem_reg});
        r1 = (r0 >= PI_S) ? r0 - TP_S : r0;
        fold_flip = 1'b0;
        r2 = r1;
        if (r1 > HP_S) begin
            r2 = PI_S - r1;
            fold_flip = 1'b1;
        end else if (r1 < -HP_S) begin
            r2 = -PI_S - r1;
            fold_flip = 1'b1;
        end
        dx = vy_reg >>> it_reg;
        dy = vx_reg >>> it_reg;
        at = rk4_pkg::atan_q30(5'(it_reg));
    end

    always_comb begin
        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        q_next     = q_reg;
        diff_next  = diff_reg;
        rem_next   = rem_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        z_next     = z_reg;
        flip_next  = flip_reg;
        it_next    = it_reg;
        unique case (state_reg)
            CS_IDLE: begin
                if (start) begin
                    neg_next   = angle[31];
                    mag_next   = angle[31] ? 32'(-angle) : angle;
                    state_next = CS_QUOT;
                end
            end
            CS_QUOT: begin
                q_next     = QW'(q_prod >> 32);
                state_next = CS_REM;
            end
            CS_REM: begin
                // below 2*2pi since the estimate is at most one low
                diff_next  = (RW+1)'(34'(mag_reg) - q_back);
                state_next = CS_CORR;
            end
            CS_CORR: begin
                rem_next   = (diff_reg >= TP_U) ? RW'(diff_reg - TP_U) : RW'(diff_reg);
                state_next = CS_FOLD;
            end
            CS_FOLD: begin
                vx_next    = rk4_pkg::CORDIC_GAIN;
                vy_next    = '0;
                z_next     = CW'(r2) <<< (30 - rk4_pkg::FRAC_BITS);
                flip_next  = fold_flip;
                it_next    = '0;
                state_next = CS_ITER;
            end
            CS_ITER: begin
                if (!z_reg[CW-1]) begin
                    vx_next = vx_reg - dx;
                    vy_next = vy_reg + dy;
                    z_next  = z_reg - at;
                end else begin
                    vx_next = vx_reg + dx;
                    vy_next = vy_reg - dy;
                    z_next  = z_reg + at;
                end
                it_next = it_reg + 1'b1;
                if (it_reg == IW'(ITERATIONS - 1)) begin
                    state_next = CS_DONE;
                end
            end
            CS_DONE: begin
                state_next = CS_IDLE;
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        q_reg    <= q_next;
        diff_reg <= diff_next;
        rem_reg  <= rem_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
        it_reg   <= it_next;
    end

    assign res.done    = (state_reg == CS_DONE);
    assign res.sin_val = vy_reg[rk4_pkg::WORD_W-1:0];
    assign res.cos_val = flip_reg ? rk4_pkg::WORD_W'(-vx_reg) : vx_reg[rk4_pkg::WORD_W-1:0];

endmodule

### rtl/rk4_ode_integrator_unit.sv
`timescale 1ns / 1ps

// RK4 integrator of dy/dx = sin(x)*cos(y), signed Q16.16. Each input transaction
// (x0, y0) starts a run that emits step_count+1 rows (n, x_n, y_n), step_count
// clamped to MAX_STEPS, tlast on the final row; s_tready is high only between
// runs. Each step evaluates four slopes, each needing two passes through the
// single sin/cos unit (modulo-2pi reduction as quotient, remainder and
// correction, fold, CORDIC_ITERATIONS rotations, then done), followed by two
// products on one shared 32x32 multiplier and the slope update. Sums
// saturate to 32 bits; slope_sum/6 truncates toward zero. Config writes
// are only expected while no run is in progress.
module rk4_ode_integrator_unit #(
    parameter int MAX_STEPS         = rk4_pkg::MAX_STEPS_DEF,
    parameter int CORDIC_ITERATIONS = rk4_pkg::CORDIC_ITER_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [20:0] cfg_wdata,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] x_start, [63:32] y_start
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [5:0] row_index, [37:6] x_value, [69:38] y_value, zero pad
    output logic        m_tlast    // last_row
);
    localparam int WW = rk4_pkg::WORD_W;
    localparam int CW = rk4_pkg::CORD_W;
    localparam int AW = rk4_pkg::ACC_W;
    localparam int NW = rk4_pkg::COUNT_W;
    localparam int FSH = 60 - rk4_pkg::FRAC_BITS;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_EMIT    = 4'd1;
    localparam logic [3:0] ST_SX_GO   = 4'd2;
    localparam logic [3:0] ST_SX_WAIT = 4'd3;
    localparam logic [3:0] ST_CY_GO   = 4'd4;
    localparam logic [3:0] ST_CY_WAIT = 4'd5;
    localparam logic [3:0] ST_MUL_F   = 4'd6;
    localparam logic [3:0] ST_MUL_H   = 4'd7;
    localparam logic [3:0] ST_SLOPE   = 4'd8;
    localparam logic [3:0] ST_DIV     = 4'd9;
    localparam logic [3:0] ST_UPD     = 4'd10;

    // config registers
    logic [rk4_pkg::STEP_W-1:0] step_size_reg;
    logic [NW-1:0]              step_count_reg;

    // sequencer state
    logic [3:0]           state_reg, state_next;
    logic [1:0]           stage_reg, stage_next;   // slope a, b, c, d
    logic signed [WW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [NW-1:0]        row_reg, row_next, steps_reg, steps_next;
    logic signed [AW-1:0] sum_reg, sum_next;
    logic signed [WW-1:0] sl_reg, sl_next;         // latest slope
    logic signed [WW-1:0] sx_reg, sx_next, cosy_reg, cosy_next;
    logic signed [63:0]   prod_reg;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [NW-1:0]        o_row_reg, o_row_next;
    logic signed [WW-1:0] o_x_reg, o_x_next, o_y_reg, o_y_next;
    logic                 o_last_reg, o_last_next;

    // datapath
    logic signed [WW-1:0] hh, xm, xh, ax, ay, f_val, slope_val, q_val;
    logic signed [WW-1:0] mul_a, mul_b;
    logic signed [63:0]   prod_next;
    logic signed [AW-1:0] sum_abs;
    logic                 cs_start;
    logic signed [WW-1:0] cs_angle;
    rk4_pkg::cs_result_t  cs_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg  <= rk4_pkg::STEP_SIZE_RST;
            step_count_reg <= rk4_pkg::STEP_COUNT_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                rk4_pkg::REG_STEP_SIZE:  step_size_reg  <= cfg_wdata;
                rk4_pkg::REG_STEP_COUNT: step_count_reg <= cfg_wdata[NW-1:0];
                default: ;
            endcase
        end
    end

    // slope arguments for the current stage
    always_comb begin
        hh = $signed({11'b0, step_size_reg[rk4_pkg::STEP_W-1:1]});
        xm = rk4_pkg::sat_word(CW'(cx_reg) + CW'(hh));
        xh = rk4_pkg::sat_word(CW'(cx_reg) + CW'($signed({11'b0, step_size_reg})));
        unique case (stage_reg)
            2'd0: begin
                ax = cx_reg;
                ay = cy_reg;
            end
            2'd1, 2'd2: begin
                ax = xm;
                ay = rk4_pkg::sat_word(CW'(cy_reg) + CW'(sl_reg >>> 1));
            end
            default: begin
                ax = xh;
                ay = rk4_pkg::sat_word(CW'(cy_reg) + CW'(sl_reg));
            end
        endcase
        cs_start = (state_reg == ST_SX_GO) || (state_reg == ST_CY_GO);
        cs_angle = (state_reg == ST_SX_GO) ? ax : ay;
    end

    rk4_cordic #(
        .ITERATIONS(CORDIC_ITERATIONS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cs_start),
        .angle   (cs_angle),
        .res     (cs_res)
    );

    // shared multiplier: sin*cos, h*f, |sum|*(1/6)
    always_comb begin
        f_val     = WW'(prod_reg >>> FSH);
        slope_val = WW'(prod_reg >>> rk4_pkg::FRAC_BITS);
        sum_abs   = sum_reg[AW-1] ? -sum_reg : sum_reg;
        q_val     = WW'(prod_reg >> rk4_pkg::RECIP_SHIFT);
        unique case (state_reg)
            ST_MUL_F: begin
                mul_a = sx_reg;
                mul_b = cosy_reg;
            end
            ST_MUL_H: begin
                mul_a = $signed({11'b0, step_size_reg});
                mul_b = f_val;
            end
            ST_DIV: begin
                mul_a = $signed(sum_abs[WW-1:0]);
                mul_b = rk4_pkg::RECIP6;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    always_comb begin
        state_next   = state_reg;
        stage_next   = stage_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        row_next     = row_reg;
        steps_next   = steps_reg;
        sum_next     = sum_reg;
        sl_next      = sl_reg;
        sx_next      = sx_reg;
        cosy_next    = cosy_reg;
        m_valid_next = m_valid_reg && !m_tready;
        o_row_next   = o_row_reg;
        o_x_next     = o_x_reg;
        o_y_next     = o_y_reg;
        o_last_next  = o_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cx_next    = $signed(s_tdata[31:0]);
                    cy_next    = $signed(s_tdata[63:32]);
                    row_next   = '0;
                    steps_next = (step_count_reg > NW'(MAX_STEPS)) ? NW'(MAX_STEPS)
                                                                   : step_count_reg;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    o_row_next   = row_reg;
                    o_x_next     = cx_reg;
                    o_y_next     = cy_reg;
                    o_last_next  = (row_reg == steps_reg);
                    stage_next   = 2'd0;
                    state_next   = (row_reg == steps_reg) ? ST_IDLE : ST_SX_GO;
                end
            end
            ST_SX_GO:   state_next = ST_SX_WAIT;
            ST_SX_WAIT: begin
                if (cs_res.done) begin
                    sx_next    = cs_res.sin_val;
                    state_next = ST_CY_GO;
                end
            end
            ST_CY_GO:   state_next = ST_CY_WAIT;
            ST_CY_WAIT: begin
                if (cs_res.done) begin
                    cosy_next  = cs_res.cos_val;
                    state_next = ST_MUL_F;
                end
            end
            ST_MUL_F:   state_next = ST_MUL_H;
            ST_MUL_H:   state_next = ST_SLOPE;
            ST_SLOPE: begin
                sl_next = slope_val;
                unique case (stage_reg)
                    2'd0:       sum_next = AW'(slope_val);
                    2'd1, 2'd2: sum_next = sum_reg + (AW'(slope_val) <<< 1);
                    default:    sum_next = sum_reg + AW'(slope_val);
                endcase
                stage_next = stage_reg + 2'd1;
                state_next = (stage_reg == 2'd3) ? ST_DIV : ST_SX_GO;
            end
            ST_DIV:     state_next = ST_UPD;
            ST_UPD: begin
                cy_next = rk4_pkg::sat_word(CW'(cy_reg) +
                                            (sum_reg[AW-1] ? -CW'(q_val) : CW'(q_val)));
                cx_next    = xh;
                row_next   = row_reg + 1'b1;
                stage_next = 2'd0;
                state_next = ST_EMIT;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            stage_reg   <= 2'd0;
            cx_reg      <= '0;
            cy_reg      <= '0;
            row_reg     <= '0;
            steps_reg   <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            stage_reg   <= stage_next;
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            row_reg     <= row_next;
            steps_reg   <= steps_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
        sl_reg     <= sl_next;
        sx_reg     <= sx_next;
        cosy_reg   <= cosy_next;
        prod_reg   <= prod_next;
        o_row_reg  <= o_row_next;
        o_x_reg    <= o_x_next;
        o_y_reg    <= o_y_next;
        o_last_reg <= o_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {2'b00, o_y_reg, o_x_reg, o_row_reg};

    // a run blocks the input until its last row is emitted
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a run is in progress");

    // a stalled row holds its payload until taken
    a_row_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("result changed while stalled");

    // sin/cos results arrive only while the sequencer waits for them
    a_cordic_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        cs_res.done |-> (state_reg == ST_SX_WAIT || state_reg == ST_CY_WAIT))
        else $error("unexpected sin/cos completion");

endmodule
